>>> rtl/core/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

    // history window and token layout
    localparam int WINDOW_DEPTH  = 4096;
    localparam int OFFSET_W      = 12;
    localparam int LEN_FIELD_W   = 4;
    localparam int LEN_BIAS      = 3;
    localparam int ITEMS_PER_FLAG = 8;
    localparam int MAX_COPY      = (1 << LEN_FIELD_W) - 1 + LEN_BIAS;
    localparam int COUNT_W       = $clog2(MAX_COPY);

    // compressed input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } lzss_in_t;

    // decoded output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } lzss_out_t;

    // decoder states
    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } lzss_state_t;

endpackage

`default_nettype wire

>>> rtl/core/lzss_stream_decoder.sv
`default_nettype none

// channel   ports                          dir  payload
// input     s_valid s_ready s_data         in   lzss_in_t  (compressed byte, final mark)
// result    m_valid m_ready m_data         out  lzss_out_t (byte, valid, run end, stream end)
//
// flag bytes, token high bytes and literals are each taken in ST_IDLE, which they do not leave
// a token low byte issues the first history read (a registered read of the history memory)
// and enters ST_COPY, which then emits one byte per cycle while the result channel is free
// the history reads as zero after reset: a fill pointer and a wrap flag mark written
// entries, so there is no clearing pass and the block is ready right after reset
// a stalled result channel freezes the copy; the pending history read is held

module lzss_stream_decoder #(
    parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  lzss_pkg::lzss_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output lzss_pkg::lzss_out_t m_data
);
    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    // history memory
    logic [7:0]          hist_mem [WINDOW_DEPTH];
    logic [7:0]          hist_rd_reg;
    logic                fwd_hit_reg;
    logic [7:0]          fwd_data_reg;
    logic                rd_live_reg;

    // control and parse state
    lzss_state_t         state_reg, state_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic                wrapped_reg, wrapped_next;
    logic [7:0]          flag_bits_reg, flag_bits_next;
    logic [3:0]          items_left_reg, items_left_next;
    logic                expect_low_reg, expect_low_next;
    logic [7:0]          token_high_reg, token_high_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                fin_reg, fin_next;
    logic                m_valid_reg, m_valid_next;
    lzss_out_t           m_data_reg, m_data_next;

    logic                out_free;
    logic                in_fire;
    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic                rd_en;
    logic [OFFSET_W-1:0] rd_offset;
    logic [AW-1:0]       rd_addr;
    logic                rd_live;
    logic                rd_fwd;
    logic [7:0]          copy_byte;
    logic [15:0]         token;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign token    = {token_high_reg, s_data.data_byte};

    // source of the next copied byte, and whether it was ever written
    assign rd_addr = wp_next - AW'(rd_offset);
    assign rd_live = wrapped_reg || (rd_addr < wp_reg);
    assign rd_fwd  = mem_we && (rd_addr == wp_reg);

    // byte returned by the last read, zero where never written
    assign copy_byte = fwd_hit_reg ? fwd_data_reg : (rd_live_reg ? hist_rd_reg : 8'd0);

    // next state and outputs
    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        flag_bits_next  = flag_bits_reg;
        items_left_next = items_left_reg;
        expect_low_next = expect_low_reg;
        token_high_next = token_high_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        fin_next        = fin_reg;
        m_valid_next    = out_free ? 1'b0 : m_valid_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_wdata       = s_data.data_byte;
        rd_en           = 1'b0;
        rd_offset       = offset_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (items_left_reg == 4'd0) begin
                        // flag byte
                        flag_bits_next  = s_data.data_byte;
                        items_left_next = 4'(ITEMS_PER_FLAG);
                    end else if (!expect_low_reg && flag_bits_reg[0]) begin
                        // literal
                        mem_we                  = 1'b1;
                        m_valid_next            = 1'b1;
                        m_data_next.out_byte    = s_data.data_byte;
                        m_data_next.byte_valid  = 1'b1;
                        m_data_next.run_last    = 1'b1;
                        m_data_next.stream_end  = s_data.final_byte;
                        flag_bits_next          = {1'b0, flag_bits_reg[7:1]};
                        items_left_next         = items_left_reg - 4'd1;
                    end else if (!expect_low_reg) begin
                        // token high byte
                        token_high_next = s_data.data_byte;
                        expect_low_next = 1'b1;
                    end else begin
                        // token low byte: start the copy
                        rd_offset       = token[15:LEN_FIELD_W];
                        rd_en           = 1'b1;
                        offset_next     = token[15:LEN_FIELD_W];
                        count_next      = COUNT_W'(token[LEN_FIELD_W-1:0])
                                        + COUNT_W'(LEN_BIAS - 1);
                        fin_next        = s_data.final_byte;
                        expect_low_next = 1'b0;
                        token_high_next = 8'd0;
                        flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                        items_left_next = items_left_reg - 4'd1;
                        state_next      = ST_COPY;
                    end

                    if (s_data.final_byte) begin
                        // bare end marker when nothing else was produced
                        if (items_left_reg == 4'd0 || (!expect_low_reg && !flag_bits_reg[0])) begin
                            m_valid_next           = 1'b1;
                            m_data_next.out_byte   = 8'd0;
                            m_data_next.byte_valid = 1'b0;
                            m_data_next.run_last   = 1'b1;
                            m_data_next.stream_end = 1'b1;
                        end
                        flag_bits_next  = 8'd0;
                        items_left_next = 4'd0;
                        expect_low_next = 1'b0;
                        token_high_next = 8'd0;
                    end
                end
            end
            ST_COPY: begin
                if (out_free) begin
                    // emit and write back one copied byte
                    mem_we                 = 1'b1;
                    mem_wdata              = copy_byte;
                    m_valid_next           = 1'b1;
                    m_data_next.out_byte   = copy_byte;
                    m_data_next.byte_valid = 1'b1;
                    m_data_next.run_last   = (count_reg == '0);
                    m_data_next.stream_end = (count_reg == '0) && fin_reg;
                    if (count_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        count_next = count_reg - COUNT_W'(1);
                        rd_en      = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // write pointer follows every history write
        if (mem_we) begin
            wp_next      = wp_reg + AW'(1);
            wrapped_next = wrapped_reg || (&wp_reg);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            flag_bits_reg  <= 8'd0;
            items_left_reg <= 4'd0;
            expect_low_reg <= 1'b0;
            token_high_reg <= 8'd0;
            count_reg      <= '0;
            fin_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            flag_bits_reg  <= flag_bits_next;
            items_left_reg <= items_left_next;
            expect_low_reg <= expect_low_next;
            token_high_reg <= token_high_next;
            count_reg      <= count_next;
            fin_reg        <= fin_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        offset_reg <= offset_next;
        m_data_reg <= m_data_next;
    end

    // history memory: one write, one registered read, forwarding on a same-entry hit
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_reg] <= mem_wdata;
        end
        if (rd_en) begin
            hist_rd_reg  <= hist_mem[rd_addr];
            fwd_hit_reg  <= rd_fwd;
            fwd_data_reg <= mem_wdata;
            rd_live_reg  <= rd_live;
        end
    end

`ifndef ASSERT_OFF
    // every history write loads a data result
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (m_valid && m_data.byte_valid))
        else $error("history write without a data result");

    // no input taken while a copy runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> !s_ready)
        else $error("input accepted during copy");

    // a copy ends with run_last and returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && out_free && count_reg == '0)
            |=> (m_data.run_last && state_reg == ST_IDLE))
        else $error("copy did not close its run");
`endif

endmodule

`default_nettype wire

>>> sim/lzss_stream_decoder_tb.sv
`timescale 1ns / 1ps

module lzss_stream_decoder_tb;

    import lzss_pkg::*;

    localparam int RANDOM_ITEMS = 85;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 19;

    // one row of stimulus, with an optional hand-written result
    typedef struct packed {
        lzss_in_t  din;
        logic      fixed;
        lzss_out_t want;
    } stim_row_t;

    // directed stream: end marker at reset, literal extremes, overlapping copy,
    // far offset, offset zero, truncated token, final literal, final token
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{'{8'h53, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h2F, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'hF0, 1'b0}, 1'b0, '0},
        '{'{8'h81, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h7E, 1'b0}, 1'b0, '0},
        '{'{8'h12, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h3C, 1'b1}, 1'b1, '{8'h3C, 1'b1, 1'b1, 1'b1}},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h1F, 1'b1}, 1'b0, '0},
        '{'{8'hFE, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
    };

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lzss_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lzss_out_t m_data;

    lzss_stream_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    stim_row_t byte_q [$];
    lzss_out_t decoded_q [$];
    lzss_out_t step_q [$];
    int        send_idx  = 0;
    int        taken     = 0;
    int        cycles    = 0;
    int        bad_cnt   = 0;
    logic      calm;

    // decoder state mirrored by the predictor
    logic [7:0]  win_mem [WINDOW_DEPTH];
    logic [11:0] wr_ptr     = '0;
    logic [7:0]  flags      = '0;
    logic [3:0]  slots_left = '0;
    logic        in_token   = 1'b0;
    logic [7:0]  tok_hi     = '0;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (taken >= 45) && (taken < 80);

    // emit one decoded byte and write it into the window
    task automatic emit_byte(input logic [7:0] b);
        lzss_out_t r;
        r = '{b, 1'b1, 1'b0, 1'b0};
        step_q.push_back(r);
        win_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
    endtask

    // decode one compressed byte into step_q
    task automatic decode_byte(input lzss_in_t din);
        logic [15:0] token;
        logic [11:0] offs;
        logic [11:0] src;
        int          run_len;
        lzss_out_t   marker;
        step_q.delete();
        if (slots_left == 0) begin
            flags      = din.data_byte;
            slots_left = 4'(ITEMS_PER_FLAG);
        end else if (!in_token) begin
            if (flags[0]) begin
                emit_byte(din.data_byte);
                flags      = flags >> 1;
                slots_left = slots_left - 4'd1;
            end else begin
                tok_hi   = din.data_byte;
                in_token = 1'b1;
            end
        end else begin
            token   = {tok_hi, din.data_byte};
            offs    = token[15:4];
            run_len = int'(token[3:0]) + LEN_BIAS;
            // byte-wise copy, so overlapping runs repeat recent output
            for (int j = 0; j < run_len; j++) begin
                src = wr_ptr - offs;
                emit_byte(win_mem[src]);
            end
            in_token   = 1'b0;
            tok_hi     = '0;
            flags      = flags >> 1;
            slots_left = slots_left - 4'd1;
        end
        if (din.final_byte) begin
            if (step_q.size() == 0) begin
                marker = '{8'h00, 1'b0, 1'b0, 1'b0};
                step_q.push_back(marker);
            end
            step_q[step_q.size() - 1].stream_end = 1'b1;
            flags      = '0;
            slots_left = '0;
            in_token   = 1'b0;
            tok_hi     = '0;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].run_last = 1'b1;
    endtask

    task automatic push_in(input logic [7:0] b, input logic fin);
        stim_row_t row;
        row = '{'{b, fin}, 1'b0, '0};
        byte_q.push_back(row);
    endtask

    // one well-formed stream of one or two flag groups, ending anywhere
    task automatic gen_stream();
        int         groups;
        int         stop;
        logic [7:0] flag;
        logic [11:0] offs;
        logic [3:0] len_code;
        logic       last;
        groups = $urandom_range(1, 2);
        for (int g = 0; g < groups; g++) begin
            flag = 8'($urandom_range(0, 255));
            stop = (g == groups - 1) ? $urandom_range(0, 8) : 8;
            push_in(flag, stop == 0);
            for (int i = 0; i < stop; i++) begin
                last = (g == groups - 1) && (i == stop - 1);
                if (flag[i]) begin
                    push_in(8'($urandom_range(0, 255)), last);
                end else begin
                    offs = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                       : 12'($urandom_range(0, 40));
                    len_code = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(0, 4));
                    if (last && $urandom_range(0, 3) == 0) begin
                        // truncated token: high byte only
                        push_in(offs[11:4], 1'b1);
                    end else begin
                        push_in(offs[11:4], 1'b0);
                        push_in({offs[3:0], len_code}, last);
                    end
                end
            end
        end
    endtask

    task automatic log_bad(input string what, input lzss_out_t want, input lzss_out_t got);
        if (bad_cnt < MAX_REPORTS)
            $display("%0t %s: exp byte %02h valid %0b last %0b end %0b, %s",
                     $time, what, want.out_byte, want.byte_valid, want.run_last,
                     want.stream_end,
                     $sformatf("got byte %02h valid %0b last %0b end %0b",
                               got.out_byte, got.byte_valid, got.run_last,
                               got.stream_end));
        bad_cnt++;
    endtask

    // input side: drive the next compressed byte, idling at random
    always @(posedge aclk) begin : drive_in
        int nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_idx <= 0;
        end else if (!s_valid || s_ready) begin
            nxt = send_idx + (s_valid ? 1 : 0);
            send_idx <= nxt;
            if (nxt < byte_q.size() && (calm || $urandom_range(0, 99) >= 11)) begin
                s_valid <= 1'b1;
                s_data  <= byte_q[nxt].din;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: stall at random
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // predict on accepted input, check accepted results
    always @(posedge aclk) begin : monitor
        lzss_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                if (byte_q[taken].fixed)
                    decoded_q.push_back(byte_q[taken].want);
                else
                    foreach (step_q[k]) decoded_q.push_back(step_q[k]);
                taken <= taken + 1;
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    log_bad("unexpected transaction", '0, m_data);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte ||
                        m_data.byte_valid !== want.byte_valid ||
                        m_data.run_last !== want.run_last ||
                        m_data.stream_end !== want.stream_end)
                        log_bad("mismatch", want, m_data);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("lzss_stream_decoder_tb: done, errors");
            $finish;
        end
    end

    initial begin
        foreach (win_mem[i]) win_mem[i] = 8'h00;

        // directed table first, then random streams with some noise
        for (int i = 0; i < DIR_ROWS; i++)
            byte_q.push_back(DIRECTED[i]);
        while (byte_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                push_in(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else
                gen_stream();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: all bytes sent and every expected result seen
        while (!(taken == byte_q.size() && decoded_q.size() == 0))
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (bad_cnt == 0 && decoded_q.size() == 0)
            $display("lzss_stream_decoder_tb: done, clean");
        else
            $display("lzss_stream_decoder_tb: done, errors");
        $finish;
    end

endmodule

>>> lzss_stream_decoder.f
rtl/core/lzss_pkg.sv
rtl/core/lzss_stream_decoder.sv
sim/lzss_stream_decoder_tb.sv
